// File: rtl/core/pkirl_pkg.sv
// ----------------------------------------------------------------------------
// pkirl_pkg
// Shared types and constants of the per-key interval rate limiter: command
// and result payloads, status codes and the probe that runs down the chain.
// ----------------------------------------------------------------------------
package pkirl_pkg;

    // Fixed payload widths
    localparam int unsigned KEY_W      = 64;
    localparam int unsigned NOW_W      = 32;
    localparam int unsigned INTERVAL_W = 20;

    // Interval register value after reset, in milliseconds
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 20'd5000;

    // Outcome of one event
    typedef enum logic [1:0] {
        ST_REFRESHED = 2'd0,
        ST_TOO_SOON  = 2'd1,
        ST_CLAIMED   = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // One input transfer
    typedef struct packed {
        logic [KEY_W-1:0] entity_key;
        logic [NOW_W-1:0] now_ms;
    } t_cmd;

    // One result transfer
    typedef struct packed {
        logic    pass;
        t_status status;
    } t_result;

    // Event travelling along the slot chain
    typedef struct packed {
        logic    vld;
        logic    done;
        t_cmd    cmd;
        t_result res;
    } t_probe;

endpackage

// File: rtl/core/per_key_interval_rate_limiter_unit.sv
// ----------------------------------------------------------------------------
// per_key_interval_rate_limiter_unit
// Per-key minimum-interval rate limiter built as a chain of slot cells.
//
//   Channel   Handshake            Payload        Notes
//   command   i_start / o_busy     i_cmd          transfer when start & !busy
//   result    o_done               o_result       one cycle, cannot be stalled
//   config    i_cfg_we             i_cfg_wdata    interval in ms, no read-back
//
// A command enters slot 0 and moves one slot per cycle; its result strobe is
// registered behind the last slot. The chain takes a new command every cycle,
// so o_busy stays low. Synchronous reset empties every slot and sets the
// interval to 5000 ms. Slot keys and times are not reset.
// ----------------------------------------------------------------------------
module per_key_interval_rate_limiter_unit
    import pkirl_pkg::*;
#(
    parameter int unsigned SLOTS     = 64,
    parameter int unsigned KEY_BITS  = 64,
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_cmd                  i_cmd,
    output logic                  o_done,
    output t_result               o_result,
    input  logic                  i_cfg_we,
    input  logic [INTERVAL_W-1:0] i_cfg_wdata
);

    logic [INTERVAL_W-1:0] r_interval;
    t_probe                head;
    t_probe                chain [SLOTS+1];
    t_probe                tail;
    logic                  r_done;
    t_result               r_result;
    t_result               n_result;

    // Interval register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RESET;
        end else if (i_cfg_we) begin
            r_interval <= i_cfg_wdata;
        end
    end

    // Build the probe for an accepted command
    always_comb begin
        head            = '0;
        head.vld        = i_start && !o_busy;
        head.cmd        = i_cmd;
        head.res.pass   = 1'b1;
        head.res.status = ST_FULL;
    end

    assign chain[0] = head;

    // Slot chain
    for (genvar g = 0; g < SLOTS; g++) begin : g_slot
        pkirl_cell #(
            .KEY_BITS  (KEY_BITS),
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_interval (r_interval),
            .i_probe    (chain[g]),
            .o_probe    (chain[g+1])
        );
    end

    assign tail = chain[SLOTS];

    // An unresolved probe found every slot taken: pass untracked
    always_comb begin
        n_result = tail.res;
        if (!tail.done) begin
            n_result.pass   = 1'b1;
            n_result.status = ST_FULL;
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= tail.vld;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_busy   = 1'b0;
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// File: rtl/core/pkirl_cell.sv
// ----------------------------------------------------------------------------
// pkirl_cell
// One slot of the table: holds a valid bit, a key and the time of the last
// passed event, resolves a probe that hits or claims it, and hands the probe
// to the next slot through its probe register.
// ----------------------------------------------------------------------------
module pkirl_cell
    import pkirl_pkg::*;
#(
    parameter int unsigned KEY_BITS  = 64,
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [INTERVAL_W-1:0] i_interval,
    input  t_probe                i_probe,
    output t_probe                o_probe
);

    // Width wide enough for both elapsed time and interval
    localparam int unsigned CMP_W = (TIME_BITS > INTERVAL_W) ? TIME_BITS : INTERVAL_W;

    logic                 r_valid;
    logic                 n_valid;
    logic [KEY_BITS-1:0]  r_key;
    logic [KEY_BITS-1:0]  n_key;
    logic [TIME_BITS-1:0] r_time;
    logic [TIME_BITS-1:0] n_time;
    t_probe               r_probe;
    t_probe               n_probe;

    logic [KEY_BITS-1:0]  probe_key;
    logic [TIME_BITS-1:0] probe_now;
    logic [TIME_BITS-1:0] elapsed;
    logic                 hit;
    logic                 too_soon;

    // Compare the probe against this slot
    assign probe_key = i_probe.cmd.entity_key[KEY_BITS-1:0];
    assign probe_now = TIME_BITS'(i_probe.cmd.now_ms);
    assign elapsed   = probe_now - r_time;
    assign hit       = r_valid && (r_key == probe_key);
    assign too_soon  = CMP_W'(elapsed) < CMP_W'(i_interval);

    // Resolve an open probe: refresh or drop on a hit, claim a free slot
    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_time  = r_time;
        n_probe = i_probe;
        if (i_probe.vld && !i_probe.done) begin
            if (hit) begin
                n_probe.done = 1'b1;
                if (too_soon) begin
                    n_probe.res.pass   = 1'b0;
                    n_probe.res.status = ST_TOO_SOON;
                end else begin
                    n_time             = probe_now;
                    n_probe.res.pass   = 1'b1;
                    n_probe.res.status = ST_REFRESHED;
                end
            end else if (!r_valid) begin
                // Slots fill in order, so no later slot can hold the key
                n_valid            = 1'b1;
                n_key              = probe_key;
                n_time             = probe_now;
                n_probe.done       = 1'b1;
                n_probe.res.pass   = 1'b1;
                n_probe.res.status = ST_CLAIMED;
            end
        end
    end

    // Slot contents and probe; reset clears only the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_probe.vld <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_probe.vld <= n_probe.vld;
        end
        r_key        <= n_key;
        r_time       <= n_time;
        r_probe.done <= n_probe.done;
        r_probe.cmd  <= n_probe.cmd;
        r_probe.res  <= n_probe.res;
    end

    assign o_probe = r_probe;

endmodule

// File: rtl/core/pkirl_checker.sv
// ----------------------------------------------------------------------------
// pkirl_checker
// Port-level checks of the rate limiter: result timing against command
// transfers, consistency of pass and status, and quiet outputs after reset.
// ----------------------------------------------------------------------------
module pkirl_checker
    import pkirl_pkg::*;
#(
    parameter int unsigned SLOTS = 64
) (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_start,
    input logic    o_busy,
    input t_cmd    i_cmd,
    input logic    o_done,
    input t_result o_result
);

    // Every command transfer yields a result after the chain latency
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##(SLOTS+1) o_done)
        else $error("command transfer without result");

    // Every result stems from a command transfer
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, SLOTS+1))
        else $error("result without command transfer");

    // Only a too-soon hit drops the event
    a_pass_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.pass == (o_result.status != ST_TOO_SOON)))
        else $error("pass flag disagrees with status");

    // No result in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe after reset");

    // Command payload must be known on every transfer
    a_cmd_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> !$isunknown(i_cmd))
        else $error("unknown command payload on transfer");

endmodule

bind per_key_interval_rate_limiter_unit pkirl_checker #(
    .SLOTS (SLOTS)
) u_pkirl_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .i_cmd    (i_cmd),
    .o_done   (o_done),
    .o_result (o_result)
);

// File: tb/sv/per_key_interval_rate_limiter_unit_tb.sv
// ----------------------------------------------------------------------------
// per_key_interval_rate_limiter_unit_tb
// Self-checking bench for the per-key interval rate limiter. A local slot
// table predicts pass and status for every command transfer. Results are
// checked in order against that prediction. Directed cases cover the interval
// boundary, key and time extremes, time wrap and backwards time, and zero and
// maximum intervals. Random traffic then drives a key pool with times steered
// around each stored time, and finally overfills the table.
// ----------------------------------------------------------------------------
module per_key_interval_rate_limiter_unit_tb
    import pkirl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH   = 64;
    localparam int LATENCY       = TABLE_DEPTH + 1;
    localparam int WATCHDOG_IDLE = 1000;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [KEY_W-1:0]      KEY_ZERO     = '0;
    localparam logic [KEY_W-1:0]      KEY_ONES     = '1;
    localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = '1;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_start     = 1'b0;
    t_cmd                  i_cmd       = '0;
    logic                  i_cfg_we    = 1'b0;
    logic [INTERVAL_W-1:0] i_cfg_wdata = '0;
    logic                  o_busy;
    logic                  o_done;
    t_result               o_result;

    // Local copy of the slot table and interval register
    bit                    tbl_valid [TABLE_DEPTH];
    logic [KEY_W-1:0]      tbl_key   [TABLE_DEPTH];
    logic [NOW_W-1:0]      tbl_time  [TABLE_DEPTH];
    logic [INTERVAL_W-1:0] cur_interval = INTERVAL_RESET;

    t_result          outcome_q [$];
    logic [KEY_W-1:0] key_pool  [$];
    int               error_count = 0;
    int               idle_cycles = 0;
    bit               no_idle     = 1'b0;

    per_key_interval_rate_limiter_unit #(
        .SLOTS     (TABLE_DEPTH),
        .KEY_BITS  (KEY_W),
        .TIME_BITS (NOW_W)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Find the lowest valid slot holding a key, or -1
    function automatic int find_slot(logic [KEY_W-1:0] key);
        for (int s = 0; s < TABLE_DEPTH; s++) begin
            if (tbl_valid[s] && tbl_key[s] == key) return s;
        end
        return -1;
    endfunction

    // Apply one event to the local table and return its outcome
    function automatic t_result limit_event(t_cmd cmd);
        t_result          res;
        int               slot;
        logic [NOW_W-1:0] elapsed;
        res.pass   = 1'b1;
        res.status = ST_FULL;
        slot = find_slot(cmd.entity_key);
        if (slot >= 0) begin
            elapsed = cmd.now_ms - tbl_time[slot];
            if (elapsed < {{(NOW_W-INTERVAL_W){1'b0}}, cur_interval}) begin
                res.pass   = 1'b0;
                res.status = ST_TOO_SOON;
            end else begin
                tbl_time[slot] = cmd.now_ms;
                res.status     = ST_REFRESHED;
            end
            return res;
        end
        for (int s = 0; s < TABLE_DEPTH; s++) begin
            if (!tbl_valid[s]) begin
                tbl_valid[s] = 1'b1;
                tbl_key[s]   = cmd.entity_key;
                tbl_time[s]  = cmd.now_ms;
                res.status   = ST_CLAIMED;
                return res;
            end
        end
        return res;
    endfunction

    // Steer the time around the stored time of a tracked key
    function automatic logic [NOW_W-1:0] pick_time(logic [KEY_W-1:0] key);
        int               slot;
        logic [NOW_W-1:0] base;
        logic [NOW_W-1:0] span;
        slot = find_slot(key);
        if (slot < 0) return $urandom();
        base = tbl_time[slot];
        span = {{(NOW_W-INTERVAL_W){1'b0}}, cur_interval};
        case ($urandom_range(0, 5))
            0: return base + span - 1;
            1: return base + span;
            2: return base + span + 1;
            3: return base + $urandom_range(0, 2 * span);
            4: return base - $urandom_range(1, 1000);
            default: return $urandom();
        endcase
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Send one command, wait for its transfer and record the outcome
    task automatic send_event(input logic [KEY_W-1:0] key, input logic [NOW_W-1:0] now);
        int   gap;
        t_cmd cmd;
        gap            = no_idle ? 0 : $urandom_range(0, 9);
        cmd.entity_key = key;
        cmd.now_ms     = now;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_cmd   <= cmd;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        outcome_q.push_back(limit_event(cmd));
    endtask

    // Hold start low until every outstanding result has arrived
    task automatic drain_results();
        i_start <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_interval(input logic [INTERVAL_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        cur_interval  = value;
    endtask

    // Random traffic over a growing key pool, with optional one-off keys
    task automatic run_random(input int count, input int pool_cap, input int noise_pct);
        logic [KEY_W-1:0] key;
        for (int n = 0; n < count; n++) begin
            if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < noise_pct) begin
                key = {$urandom(), $urandom()};
            end else if (key_pool.size() == 0 ||
                         (key_pool.size() < pool_cap && $urandom_range(0, 9) == 0)) begin
                key = {$urandom(), $urandom()};
                key_pool.push_back(key);
            end else begin
                key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            end
            send_event(key, pick_time(key));
        end
        no_idle = 1'b0;
    endtask

    // Claims, interval boundary, key extremes, time wrap and backwards time
    task automatic test_default_interval();
        send_event(KEY_ZERO, 32'd0);
        send_event(KEY_ONES, 32'hFFFF_FFFF);
        send_event(KEY_ZERO, 32'd4999);
        send_event(KEY_ZERO, 32'd5000);
        send_event(KEY_ONES, 32'd4998);
        send_event(KEY_ONES, 32'd4999);
        send_event(KEY_ZERO, 32'd100);
        send_event(64'd1, 32'd100);
        send_event(64'h8000_0000_0000_0000, 32'h8000_0000);
        send_event(64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF);
    endtask

    // Interval zero: nothing is dropped, even at the same time
    task automatic test_zero_interval();
        set_interval('0);
        send_event(KEY_ZERO, 32'd100);
        send_event(64'd1, 32'd100);
        send_event(KEY_ONES, 32'd4999);
    endtask

    // Largest register value
    task automatic test_max_interval();
        set_interval(INTERVAL_MAX);
        send_event(64'd1, 32'd100 + 32'd1048574);
        send_event(64'd1, 32'd100 + 32'd1048575);
        send_event(KEY_ONES, 32'd4999 + 32'd1048575);
        send_event(KEY_ZERO, 32'd99);
    endtask

    // Random traffic within table capacity over several intervals
    task automatic test_random_tracked();
        set_interval(INTERVAL_RESET);
        run_random(300, 40, 0);
        set_interval('0);
        run_random(150, 40, 0);
        set_interval(INTERVAL_W'($urandom_range(1, 64)));
        run_random(150, 40, 0);
        set_interval(INTERVAL_W'(600000));
        run_random(200, 40, 0);
        set_interval(INTERVAL_MAX);
        run_random(150, 40, 0);
    endtask

    // Overfill the table, then keep hitting tracked and untracked keys
    task automatic test_table_full();
        set_interval(INTERVAL_RESET);
        run_random(300, 120, 15);
        set_interval(INTERVAL_W'($urandom_range(0, 1048575)));
        run_random(150, 120, 10);
    endtask

    // Check every result against the oldest outcome
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (outcome_q.size() == 0) begin
                note_error("result with no outstanding command");
            end else begin
                want = outcome_q.pop_front();
                if (o_result.pass !== want.pass || o_result.status !== want.status) begin
                    note_error($sformatf("expected pass=%0d status=%s, got pass=%0d status=%0d",
                                         want.pass, want.status.name(),
                                         o_result.pass, o_result.status));
                end
            end
        end
    end

    // Abort when no transfer of either kind happens for too long
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_IDLE) begin
            $display("per_key_interval_rate_limiter_unit_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_interval();
        test_zero_interval();
        test_max_interval();
        test_random_tracked();
        test_table_full();
        drain_results();
        repeat (LATENCY + 16) @(posedge i_clk);
        if (error_count == 0) begin
            $display("per_key_interval_rate_limiter_unit_tb OK");
        end else begin
            $display("per_key_interval_rate_limiter_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
